// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the slot map checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GLAM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("glam assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GLAM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("glam assertion failed");

`endif

// File: hw/rtl/glam_pkg.sv
// ----------------------------------------------------------------------------
// glam_pkg
// Types and constants shared by the glyph atlas slot map modules.
// ----------------------------------------------------------------------------
package glam_pkg;

  localparam int CP_W       = 21;
  localparam int SLOT_OUT_W = 8;
  localparam int TILE_W     = 4;
  localparam int GRID_DIM   = 16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EV_ORD,
    ST_EV_TAG,
    ST_EV_WR,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    SRC_HIT,
    SRC_FILL,
    SRC_ORD
  } slot_src_t;

  typedef struct packed {
    logic      accept;
    logic      srch_step;
    logic      s_load;
    slot_src_t s_src;
    logic      ord0_rd;
    logic      tag_ev_rd;
    logic      tag_wr;
    logic      ev_take;
    logic      scan_init;
    logic      scan_step;
    logic      finish;
  } cmd_t;

  typedef struct packed {
    logic match;
    logic srch_done;
    logic full;
    logic append;
    logic scan_done;
  } sts_t;

endpackage

// File: hw/rtl/glam_ram.sv
// ----------------------------------------------------------------------------
// glam_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module glam_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/glam_ctrl.sv
// ----------------------------------------------------------------------------
// glam_ctrl
// Request sequencer: tag search, eviction and recency update.
// ----------------------------------------------------------------------------
module glam_ctrl import glam_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  sts_t sts,
  output logic busy,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (sts.match) begin
          cmd.s_load    = 1'b1;
          cmd.s_src     = SRC_HIT;
          cmd.scan_init = 1'b1;
          state_nxt     = ST_SCAN;
        end else if (sts.srch_done) begin
          if (sts.full) begin
            state_nxt = ST_EV_ORD;
          end else begin
            cmd.s_load = 1'b1;
            cmd.s_src  = SRC_FILL;
            state_nxt  = ST_DONE;
          end
        end else begin
          cmd.srch_step = 1'b1;
        end
      end
      ST_EV_ORD: begin
        cmd.ord0_rd = 1'b1;
        state_nxt   = ST_EV_TAG;
      end
      ST_EV_TAG: begin
        cmd.tag_ev_rd = 1'b1;
        cmd.s_load    = 1'b1;
        cmd.s_src     = SRC_ORD;
        state_nxt     = ST_EV_WR;
      end
      ST_EV_WR: begin
        cmd.ev_take   = 1'b1;
        cmd.tag_wr    = 1'b1;
        cmd.scan_init = 1'b1;
        state_nxt     = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        cmd.tag_wr = sts.append;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/glam_dp.sv
// ----------------------------------------------------------------------------
// glam_dp
// Slot map datapath: tag and recency memories, occupancy count, search and
// scan pointers and result registers.
// ----------------------------------------------------------------------------
module glam_dp import glam_pkg::*; #(
  parameter int SLOTS = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic [CP_W-1:0]       in_code_point,
  output logic                  out_valid,
  output logic [SLOT_OUT_W-1:0] out_slot,
  output logic                  out_hit,
  output logic [TILE_W-1:0]     out_tile_col,
  output logic [TILE_W-1:0]     out_tile_row,
  output logic                  out_evicted_valid,
  output logic [CP_W-1:0]       out_evicted_code_point
);

  localparam int IW      = $clog2(SLOTS);
  localparam int OAW     = $clog2(SLOTS - 1);
  localparam int GRID_SH = $clog2(GRID_DIM);

  logic [CP_W-1:0] cp_r;
  logic [IW:0]     idx_r;
  logic            pend_r;
  logic [IW-1:0]   pend_addr_r;
  logic [IW-1:0]   cnt_r;
  logic [IW-1:0]   s_r;
  logic            hit_r;
  logic            append_r;
  logic            found_r;
  logic            ev_valid_r;
  logic [CP_W-1:0] ev_cp_r;

  logic                  out_valid_r;
  logic [SLOT_OUT_W-1:0] out_slot_r;
  logic                  out_hit_r;
  logic [TILE_W-1:0]     out_tile_col_r;
  logic [TILE_W-1:0]     out_tile_row_r;
  logic                  out_ev_valid_r;
  logic [CP_W-1:0]       out_ev_cp_r;

  logic [CP_W-1:0] tag_q;
  logic [IW-1:0]   ord_q;
  logic [IW-1:0]   tag_raddr;
  logic [OAW-1:0]  ord_raddr;
  logic            ord_we;
  logic [OAW-1:0]  ord_waddr;
  logic [IW-1:0]   ord_wdata;
  logic [IW-1:0]   ev_slot;
  logic            srch_issue;
  logic            scan_issue;

  assign srch_issue = (idx_r <= {1'b0, cnt_r});
  assign scan_issue = (idx_r < {1'b0, cnt_r});
  assign ev_slot    = (ord_q == '0) ? IW'(1) : ord_q;
  assign tag_raddr  = cmd.tag_ev_rd ? ev_slot : idx_r[IW-1:0];
  assign ord_raddr  = cmd.ord0_rd ? '0 : OAW'(idx_r);

  always_comb begin
    ord_we    = 1'b0;
    ord_waddr = OAW'(pend_addr_r - IW'(1));
    ord_wdata = ord_q;
    if (cmd.finish) begin
      ord_we    = 1'b1;
      ord_waddr = append_r ? OAW'(cnt_r) : OAW'(cnt_r - IW'(1));
      ord_wdata = s_r;
    end else if (cmd.scan_step && pend_r && found_r) begin
      ord_we = 1'b1;
    end
  end

  assign sts.match     = pend_r && (tag_q == cp_r);
  assign sts.srch_done = !srch_issue && !pend_r;
  assign sts.full      = (cnt_r == IW'(SLOTS - 1));
  assign sts.append    = append_r;
  assign sts.scan_done = !scan_issue && !pend_r;

  glam_ram #(
    .WIDTH (CP_W),
    .DEPTH (SLOTS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (cmd.tag_wr),
    .waddr (s_r),
    .wdata (cp_r),
    .raddr (tag_raddr),
    .rdata (tag_q)
  );

  glam_ram #(
    .WIDTH (IW),
    .DEPTH (SLOTS - 1)
  ) u_ord_ram (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (ord_wdata),
    .raddr (ord_raddr),
    .rdata (ord_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
      if (cmd.accept) begin
        cp_r       <= in_code_point;
        idx_r      <= (IW + 1)'(1);
        pend_r     <= 1'b0;
        hit_r      <= 1'b0;
        append_r   <= 1'b0;
        found_r    <= 1'b0;
        ev_valid_r <= 1'b0;
        ev_cp_r    <= '0;
      end
      if (cmd.srch_step) begin
        idx_r       <= idx_r + (IW + 1)'(1);
        pend_r      <= srch_issue;
        pend_addr_r <= idx_r[IW-1:0];
      end
      if (cmd.s_load) begin
        case (cmd.s_src)
          SRC_HIT: begin
            s_r   <= pend_addr_r;
            hit_r <= 1'b1;
          end
          SRC_FILL: begin
            s_r      <= cnt_r + IW'(1);
            append_r <= 1'b1;
          end
          SRC_ORD: begin
            s_r <= ev_slot;
          end
          default: begin
            s_r <= s_r;
          end
        endcase
      end
      if (cmd.ev_take) begin
        ev_valid_r <= 1'b1;
        ev_cp_r    <= tag_q;
      end
      if (cmd.scan_init) begin
        idx_r   <= '0;
        pend_r  <= 1'b0;
        found_r <= 1'b0;
      end
      if (cmd.scan_step) begin
        idx_r       <= idx_r + (IW + 1)'(1);
        pend_r      <= scan_issue;
        pend_addr_r <= idx_r[IW-1:0];
        if (pend_r && !found_r && (ord_q == s_r)) begin
          found_r <= 1'b1;
        end
      end
      if (cmd.finish) begin
        if (append_r) begin
          cnt_r <= cnt_r + IW'(1);
        end
        out_slot_r     <= SLOT_OUT_W'(s_r);
        out_hit_r      <= hit_r;
        out_tile_col_r <= TILE_W'(s_r & IW'(GRID_DIM - 1));
        out_tile_row_r <= TILE_W'(s_r >> GRID_SH);
        out_ev_valid_r <= ev_valid_r;
        out_ev_cp_r    <= ev_cp_r;
      end
    end
  end

  assign out_valid              = out_valid_r;
  assign out_slot               = out_slot_r;
  assign out_hit                = out_hit_r;
  assign out_tile_col           = out_tile_col_r;
  assign out_tile_row           = out_tile_row_r;
  assign out_evicted_valid      = out_ev_valid_r;
  assign out_evicted_code_point = out_ev_cp_r;

endmodule

// File: hw/rtl/glyph_atlas_lru_slot_map_core.sv
// ----------------------------------------------------------------------------
// glyph_atlas_lru_slot_map_core
// Maps code points to atlas slots with least recently used replacement.
//
// Channel   Ports                          Transfer
// request   start, busy, in_code_point     start high while busy is low
// result    out_valid, out_*               out_valid high for one cycle
//
// Every request starts with a tag search. A hit or an eviction is then followed
// by a recency scan; a fill of a free slot is not.
// The tag search and the recency scan each read one entry per cycle.
// Reset clears the occupancy count and control flags, so no clearing pass is needed.
// Results cannot be stalled; a new request may start during the result cycle.
// ----------------------------------------------------------------------------
module glyph_atlas_lru_slot_map_core import glam_pkg::*; #(
  parameter int SLOTS = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [CP_W-1:0]       in_code_point,
  output logic                  out_valid,
  output logic [SLOT_OUT_W-1:0] out_slot,
  output logic                  out_hit,
  output logic [TILE_W-1:0]     out_tile_col,
  output logic [TILE_W-1:0]     out_tile_row,
  output logic                  out_evicted_valid,
  output logic [CP_W-1:0]       out_evicted_code_point
);

  cmd_t cmd;
  sts_t sts;

  glam_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  glam_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .sts                    (sts),
    .in_code_point          (in_code_point),
    .out_valid              (out_valid),
    .out_slot               (out_slot),
    .out_hit                (out_hit),
    .out_tile_col           (out_tile_col),
    .out_tile_row           (out_tile_row),
    .out_evicted_valid      (out_evicted_valid),
    .out_evicted_code_point (out_evicted_code_point)
  );

endmodule

// File: hw/rtl/glam_sva_chk.sv
// ----------------------------------------------------------------------------
// glam_sva_chk
// Port-level checks on the slot map core, attached by a bind statement.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module glam_sva_chk import glam_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input logic                  out_valid,
  input logic [SLOT_OUT_W-1:0] out_slot,
  input logic                  out_hit,
  input logic [TILE_W-1:0]     out_tile_col,
  input logic [TILE_W-1:0]     out_tile_row,
  input logic                  out_evicted_valid,
  input logic [CP_W-1:0]       out_evicted_code_point
);

  logic ev_clear;

  assign ev_clear = !out_evicted_valid && (out_evicted_code_point == '0);

  `GLAM_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid)
  `GLAM_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `GLAM_ASSERT_SAME(a_done_strobe, $fell(busy) && $past(rst_n), out_valid)
  `GLAM_ASSERT_SAME(a_hit_no_evict, out_valid && out_hit, ev_clear)
  `GLAM_ASSERT_SAME(a_tile_split, out_valid, {out_tile_row, out_tile_col} == out_slot)

endmodule

bind glyph_atlas_lru_slot_map_core glam_sva_chk u_glam_sva_chk (.*);

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Glyph atlas slot map testbench
// Sends code point requests to the slot map in bursts with random gaps. A
// scoreboard keeps its own copy of the tags, valid bits and recency list, and
// it checks every result against the oldest expected one. Directed requests
// cover the extremes of the code point range first. Random phases then vary
// the working set so that hits, fills and evictions all occur.
// ----------------------------------------------------------------------------
module testbench;
  import glam_pkg::*;

  localparam int SLOT_COUNT     = 256;
  localparam int GRID_SIZE      = 16;
  localparam int POOL_SIZE      = 400;
  localparam int PHASE_ITEMS    = 193;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic [SLOT_OUT_W-1:0] slot;
    logic                  hit;
    logic [TILE_W-1:0]     tile_col;
    logic [TILE_W-1:0]     tile_row;
    logic                  evicted_valid;
    logic [CP_W-1:0]       evicted_code_point;
  } atlas_result_t;

  class atlas_scoreboard;
    logic [CP_W-1:0] tag_mem [SLOT_COUNT];
    bit              valid_mem [SLOT_COUNT];
    logic [7:0]      lru_q [$];
    atlas_result_t   expected_q [$];
    int              errors;
    int              hits;
    int              fills;
    int              evictions;
    int              checked;

    function void note_request(logic [CP_W-1:0] cp);
      atlas_result_t r;
      int            s;
      int            pos;
      r = '0;
      s = 0;
      for (int i = 1; i < SLOT_COUNT; i++) begin
        if (valid_mem[i] && tag_mem[i] == cp) begin
          s = i;
          break;
        end
      end
      if (s != 0) begin
        r.hit = 1'b1;
        hits++;
      end else begin
        if (lru_q.size() >= SLOT_COUNT - 1) begin
          s = lru_q[0];
          if (s == 0) s = 1;
          if (valid_mem[s]) begin
            r.evicted_valid      = 1'b1;
            r.evicted_code_point = tag_mem[s];
            evictions++;
          end
        end else begin
          s = lru_q.size() + 1;
          fills++;
        end
        tag_mem[s]   = cp;
        valid_mem[s] = 1'b1;
      end
      pos = -1;
      for (int i = 0; i < lru_q.size(); i++) begin
        if (lru_q[i] == s) begin
          pos = i;
          break;
        end
      end
      if (pos >= 0) begin
        lru_q.delete(pos);
        lru_q = {lru_q, s[7:0]};
      end else if (lru_q.size() < SLOT_COUNT - 1) begin
        lru_q = {lru_q, s[7:0]};
      end
      r.slot     = s[SLOT_OUT_W-1:0];
      r.tile_col = TILE_W'(s % GRID_SIZE);
      r.tile_row = TILE_W'(s / GRID_SIZE);
      expected_q = {expected_q, r};
    endfunction

    function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
      if (exp_val !== act_val) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_val,
                 act_val);
      end
    endfunction

    function void check_result(atlas_result_t act);
      atlas_result_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual slot %0d", $time, act.slot);
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      compare_field("slot", 32'(exp_r.slot), 32'(act.slot));
      compare_field("hit", 32'(exp_r.hit), 32'(act.hit));
      compare_field("tile_col", 32'(exp_r.tile_col), 32'(act.tile_col));
      compare_field("tile_row", 32'(exp_r.tile_row), 32'(act.tile_row));
      compare_field("evicted_valid", 32'(exp_r.evicted_valid), 32'(act.evicted_valid));
      compare_field("evicted_code_point", 32'(exp_r.evicted_code_point),
                    32'(act.evicted_code_point));
    endfunction
  endclass

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  start         = 1'b0;
  logic [CP_W-1:0]       in_code_point = '0;
  logic                  busy;
  logic                  out_valid;
  logic [SLOT_OUT_W-1:0] out_slot;
  logic                  out_hit;
  logic [TILE_W-1:0]     out_tile_col;
  logic [TILE_W-1:0]     out_tile_row;
  logic                  out_evicted_valid;
  logic [CP_W-1:0]       out_evicted_code_point;

  atlas_scoreboard sb = new;
  int              stall_cycles = 0;
  int              burst_left   = 1;
  logic [CP_W-1:0] pool [POOL_SIZE];
  int              windows [6] = '{40, 300, 260, 400, 120, 280};

  glyph_atlas_lru_slot_map_core #(
    .SLOTS(SLOT_COUNT)
  ) i_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_code_point         (in_code_point),
    .out_valid             (out_valid),
    .out_slot              (out_slot),
    .out_hit               (out_hit),
    .out_tile_col          (out_tile_col),
    .out_tile_row          (out_tile_row),
    .out_evicted_valid     (out_evicted_valid),
    .out_evicted_code_point(out_evicted_code_point)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_result('{slot: out_slot, hit: out_hit, tile_col: out_tile_col,
                        tile_row: out_tile_row, evicted_valid: out_evicted_valid,
                        evicted_code_point: out_evicted_code_point});
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("** glyph_atlas_lru_slot_map_core: FAILED **");
        $finish;
      end
    end
  end

  task automatic send_code_point(input logic [CP_W-1:0] cp);
    @(negedge clk);
    start         <= 1'b1;
    in_code_point <= cp;
    do @(posedge clk); while (busy);
    sb.note_request(cp);
  endtask

  task automatic pace_sender();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(30, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(40, 1);
      if (gap > 0) begin
        @(negedge clk);
        start         <= 1'b0;
        in_code_point <= CP_W'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [CP_W-1:0] directed [12];
    logic [CP_W-1:0] cp;

    directed = '{
      21'h000000, 21'h1FFFFF, 21'h10FFFF, 21'h110000, 21'h000000, 21'h155555,
      21'h0AAAAA, 21'h1FFFFF, 21'h000041, 21'h000041, 21'h10FFFF, 21'h155555
    };
    foreach (pool[i]) pool[i] = CP_W'($urandom);
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_code_point(directed[i]);
    drain_results();

    foreach (windows[p]) begin
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < 20) cp = CP_W'($urandom);
        else cp = pool[$urandom_range(windows[p] - 1)];
        send_code_point(cp);
        pace_sender();
      end
      drain_results();
    end

    repeat (40) @(posedge clk);
    $display("Checked %0d results: %0d hits, %0d fills of free slots, %0d evictions.",
             sb.checked, sb.hits, sb.fills, sb.evictions);
    if (sb.errors == 0) begin
      $display("** glyph_atlas_lru_slot_map_core: PASSED **");
    end else begin
      $display("%0d mismatches found.", sb.errors);
      $display("** glyph_atlas_lru_slot_map_core: FAILED **");
    end
    $finish;
  end

endmodule
